### rtl/tdfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfa_pkg
// Shared types and constants of the table-driven automaton engine: item
// layouts, opcodes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package tdfa_pkg;

    // default table dimensions
    localparam int TDFA_MAX_STATES  = 16;
    localparam int TDFA_MAX_LETTERS = 32;

    // fixed field widths
    localparam int STATE_W  = 4;
    localparam int LETTER_W = 5;
    localparam int ALPHA_W  = 6;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // register reset values
    localparam logic [STATE_W-1:0] START_RST = 4'd0;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 6'd2;
    localparam logic [COUNT_W-1:0] COUNT_RST = 5'd4;

    // item opcodes
    typedef enum logic [1:0] {
        OP_TRANS  = 2'd0,
        OP_MARK   = 2'd1,
        OP_LETTER = 2'd2,
        OP_NOP    = 2'd3
    } tdfa_op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE   = 2'd0,
        CFG_ALPHABET_SIZE = 2'd1,
        CFG_STATE_COUNT   = 2'd2
    } tdfa_cfg_idx_t;

    // input item
    typedef struct packed {
        logic [1:0]          opcode;
        logic [STATE_W-1:0]  entry_state;
        logic [LETTER_W-1:0] letter;
        logic [STATE_W-1:0]  target_state;
        logic                accepting;
        logic                word_end;
    } tdfa_in_t;

    // result item
    typedef struct packed {
        logic [STATE_W-1:0] current_state;
        logic               word_done;
        logic               word_accepted;
        logic               range_error;
    } tdfa_out_t;

endpackage

### rtl/tdfa_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfa_table
// Transition table storage: one write port and one read port with a
// registered read data output. Contents are undefined until written.
// ----------------------------------------------------------------------------
module tdfa_table #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/table_driven_dfa_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_dfa_engine_top
// Programmable deterministic automaton: load items program the transition
// table and accepting marks, letter items walk the table one letter a cycle while the result channel does not stall.
// ----------------------------------------------------------------------------
// The engine takes one item every clock cycle while the result channel does not
// stall, and returns one result per item. An accepted item enters the work
// stage and moves into the result register when that register is empty or
// not stalled. The transition lookup for a letter is a synchronous read of
// the table memory addressed at the accepting edge; the next letter's address
// is formed from that read data in the following cycle, so letters of one word
// stream at full rate. Table writes and mark writes take effect for the very
// next item. The table holds garbage until programmed and needs no clearing
// pass; accepting marks reset to zero. The configuration port is always ready
// and is meant to be written while idle.
// ----------------------------------------------------------------------------
module table_driven_dfa_engine_top #(
    parameter int MAX_STATES  = tdfa_pkg::TDFA_MAX_STATES,
    parameter int MAX_LETTERS = tdfa_pkg::TDFA_MAX_LETTERS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tdfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdfa_pkg::CFG_DATA_W-1:0]     cfg_data,
    // item input channel
    input  logic                                sym_valid,
    output logic                                sym_stall,
    input  tdfa_pkg::tdfa_in_t                  sym_item,
    // result channel
    output logic                                res_valid,
    input  logic                                res_stall,
    output tdfa_pkg::tdfa_out_t                 res_item
);

    import tdfa_pkg::*;

    localparam int SW = (MAX_STATES  > 1) ? $clog2(MAX_STATES)  : 1;
    localparam int LW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int AW = SW + LW;

    // work stage between the input and the result register
    typedef struct packed {
        logic [1:0]         op;
        logic [STATE_W-1:0] base;
        logic               err;
        logic               wend;
        logic               iw_after;
    } stage_t;

    logic [STATE_W-1:0] start_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [MAX_STATES-1:0] marks_reg;
    logic [STATE_W-1:0]    rs_reg;
    logic                  iw_reg;

    stage_t    p_reg;
    stage_t    p_next;
    logic      p_vld_reg;
    logic      out_vld_reg;
    tdfa_out_t out_reg;

    logic               sym_acc;
    logic               p_fire;
    logic [STATE_W-1:0] eff_state;
    logic [STATE_W-1:0] cur_state;
    logic               cur_in;
    logic [STATE_W-1:0] st0;
    logic               est_bad;
    logic               tgt_bad;
    logic               let_bad;
    logic               st0_bad;
    logic               item_err;
    tdfa_out_t          res_next;

    logic              tbl_wr_en;
    logic [AW-1:0]     tbl_wr_addr;
    logic              tbl_rd_en;
    logic [AW-1:0]     tbl_rd_addr;
    logic [STATE_W-1:0] tbl_rd_data;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RST;
            alpha_reg <= ALPHA_RST;
            count_reg <= COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_STATE:   start_reg <= cfg_data[STATE_W-1:0];
                CFG_ALPHABET_SIZE: alpha_reg <= cfg_data[ALPHA_W-1:0];
                CFG_STATE_COUNT:   count_reg <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // handshakes
    assign p_fire    = p_vld_reg && (!out_vld_reg || !res_stall);
    assign sym_stall = p_vld_reg && !p_fire;
    assign sym_acc   = sym_valid && !sym_stall;

    // state left behind by the item in the work stage
    assign eff_state = (p_reg.op == OP_LETTER && !p_reg.err) ? tbl_rd_data : p_reg.base;
    assign cur_state = p_vld_reg ? eff_state : rs_reg;
    assign cur_in    = p_vld_reg ? p_reg.iw_after : iw_reg;

    // word start loads the start state
    assign st0 = cur_in ? cur_state : start_reg;

    // range checks against configured and built-in limits
    assign est_bad = ({1'b0, sym_item.entry_state} >= count_reg)
                  || (32'(sym_item.entry_state) >= MAX_STATES);
    assign tgt_bad = ({1'b0, sym_item.target_state} >= count_reg)
                  || (32'(sym_item.target_state) >= MAX_STATES);
    assign st0_bad = ({1'b0, st0} >= count_reg) || (32'(st0) >= MAX_STATES);
    assign let_bad = ({1'b0, sym_item.letter} >= alpha_reg)
                  || (32'(sym_item.letter) >= MAX_LETTERS);

    // per-opcode error and next stage contents
    always_comb
    begin
        p_next          = p_reg;
        item_err        = 1'b0;
        p_next.op       = sym_item.opcode;
        p_next.base     = cur_state;
        p_next.wend     = sym_item.word_end;
        p_next.iw_after = cur_in;
        case (sym_item.opcode)
            OP_TRANS:  item_err = est_bad || let_bad || tgt_bad;
            OP_MARK:   item_err = est_bad;
            OP_LETTER:
            begin
                item_err        = let_bad || st0_bad;
                p_next.base     = st0;
                p_next.iw_after = !sym_item.word_end;
            end
            default:   item_err = 1'b0;
        endcase
        p_next.err = item_err;
    end

    // table access at the accepting edge
    assign tbl_wr_en   = sym_acc && (sym_item.opcode == OP_TRANS) && !item_err;
    assign tbl_wr_addr = {SW'(sym_item.entry_state), LW'(sym_item.letter)};
    assign tbl_rd_en   = sym_acc && (sym_item.opcode == OP_LETTER) && !item_err;
    assign tbl_rd_addr = {SW'(st0), LW'(sym_item.letter)};

    tdfa_table #(
        .ADDR_W (AW),
        .DATA_W (STATE_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (sym_item.target_state),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // accepting marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else if (sym_acc && (sym_item.opcode == OP_MARK) && !item_err)
        begin
            marks_reg[SW'(sym_item.entry_state)] <= sym_item.accepting;
        end
    end

    // work stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (sym_acc)
        begin
            p_vld_reg <= 1'b1;
        end
        else if (p_fire)
        begin
            p_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym_acc)
        begin
            p_reg <= p_next;
        end
    end

    // result of the item in the work stage
    always_comb
    begin
        res_next.current_state = eff_state;
        res_next.word_done     = (p_reg.op == OP_LETTER) && p_reg.wend;
        res_next.word_accepted = res_next.word_done && (32'(eff_state) < MAX_STATES)
                              && marks_reg[SW'(eff_state)];
        res_next.range_error   = (p_reg.op != OP_NOP) && p_reg.err;
    end

    // committed running state and word flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg <= '0;
            iw_reg <= 1'b0;
        end
        else if (p_fire)
        begin
            rs_reg <= eff_state;
            iw_reg <= p_reg.iw_after;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (p_fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_fire)
        begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_vld_reg;
    assign res_item  = out_reg;

    // an empty work stage never holds off the input
    a_no_stall_when_empty : assert property (
        @(posedge clk) disable iff (!rst_n)
        !p_vld_reg |-> !sym_stall
    ) else $error("input stalled with an empty work stage");

    // a word-ending letter closes the word
    a_word_closes : assert property (
        @(posedge clk) disable iff (!rst_n)
        (p_fire && p_reg.op == OP_LETTER && p_reg.wend) |=> !iw_reg
    ) else $error("word still open after its last letter");

    // a clean letter commits the looked-up state
    a_lookup_commit : assert property (
        @(posedge clk) disable iff (!rst_n)
        (p_fire && p_reg.op == OP_LETTER && !p_reg.err) |=> (rs_reg == $past(tbl_rd_data))
    ) else $error("running state differs from table lookup");

    // an item is never taken while the work stage is blocked
    a_no_overrun : assert property (
        @(posedge clk) disable iff (!rst_n)
        (p_vld_reg && out_vld_reg && res_stall) |-> !sym_acc
    ) else $error("item accepted over a blocked work stage");

endmodule

### tb/tb_table_driven_dfa_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_driven_dfa_engine_top
// Self-checking bench for the table-driven automaton engine. A local model of
// the table, marks and running state predicts every result in order; words,
// table loads, out-of-range items and register changes are driven under
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_table_driven_dfa_engine_top;
    import tdfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  sym_valid = 1'b0;
    logic                  sym_stall;
    tdfa_in_t              sym_item = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    tdfa_out_t             res_item;

    // automaton model state
    logic [STATE_W-1:0] next_state [TDFA_MAX_STATES][TDFA_MAX_LETTERS];
    bit                 entry_written [TDFA_MAX_STATES][TDFA_MAX_LETTERS] = '{default: 1'b0};
    bit                 accept_mark [TDFA_MAX_STATES] = '{default: 1'b0};
    logic [STATE_W-1:0] walk_state = '0;
    bit                 word_open = 1'b0;
    logic [STATE_W-1:0] cfg_start = START_RST;
    logic [ALPHA_W-1:0] cfg_alpha = ALPHA_RST;
    logic [COUNT_W-1:0] cfg_count = COUNT_RST;

    tdfa_out_t expected_outcomes [$];
    int items_sent = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    // idling controls
    int gap_max = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    table_driven_dfa_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym_item  (sym_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #6 clk = ~clk;

    // effective sizes
    function automatic int live_states();
        return (cfg_count < TDFA_MAX_STATES) ? int'(cfg_count) : TDFA_MAX_STATES;
    endfunction

    function automatic int live_letters();
        return (cfg_alpha < TDFA_MAX_LETTERS) ? int'(cfg_alpha) : TDFA_MAX_LETTERS;
    endfunction

    // state the next letter starts from
    function automatic logic [STATE_W-1:0] word_state();
        return word_open ? walk_state : cfg_start;
    endfunction

    // true when a letter would look up a table entry never programmed
    function automatic bit hits_blank_entry(logic [LETTER_W-1:0] letter);
        logic [STATE_W-1:0] st;
        st = word_state();
        return (letter < live_letters()) && (st < live_states())
            && !entry_written[st][letter];
    endfunction

    // expected result of one item, updates the model
    function automatic tdfa_out_t advance_automaton(tdfa_in_t it);
        tdfa_out_t r;
        int slim;
        int llim;
        slim = live_states();
        llim = live_letters();
        r = '0;
        case (it.opcode)
            OP_TRANS:
            begin
                if (it.entry_state >= slim || it.letter >= llim || it.target_state >= slim)
                    r.range_error = 1'b1;
                else
                begin
                    next_state[it.entry_state][it.letter] = it.target_state;
                    entry_written[it.entry_state][it.letter] = 1'b1;
                end
            end
            OP_MARK:
            begin
                if (it.entry_state >= slim)
                    r.range_error = 1'b1;
                else
                    accept_mark[it.entry_state] = it.accepting;
            end
            OP_LETTER:
            begin
                if (!word_open)
                begin
                    walk_state = cfg_start;
                    word_open = 1'b1;
                end
                if (it.letter >= llim || walk_state >= slim)
                    r.range_error = 1'b1;
                else
                    walk_state = next_state[walk_state][it.letter];
                if (it.word_end)
                begin
                    r.word_done = 1'b1;
                    r.word_accepted = accept_mark[walk_state];
                    word_open = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.current_state = walk_state;
        return r;
    endfunction

    function automatic tdfa_in_t make_item(tdfa_op_t op, int est, int letter, int tgt,
                                           int acc, int wend);
        tdfa_in_t it;
        it.opcode       = op;
        it.entry_state  = est[STATE_W-1:0];
        it.letter       = letter[LETTER_W-1:0];
        it.target_state = tgt[STATE_W-1:0];
        it.accepting    = acc[0];
        it.word_end     = wend[0];
        return it;
    endfunction

    function automatic tdfa_in_t random_item();
        logic [$bits(tdfa_in_t)-1:0] raw;
        raw = $bits(tdfa_in_t)'($urandom);
        return raw;
    endfunction

    // send one item in bursts with random gaps between them
    task automatic send_item(tdfa_in_t it);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0)
                gap = $urandom_range(1, gap_max);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            sym_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sym_item  <= it;
        sym_valid <= 1'b1;
        expected_outcomes.push_back(advance_automaton(it));
        items_sent++;
        do @(posedge clk); while (sym_stall);
    endtask

    // program the entry a letter is about to read, if it was never written
    task automatic send_checked(tdfa_in_t it);
        tdfa_in_t fill;
        if (it.opcode == OP_LETTER && hits_blank_entry(it.letter))
        begin
            fill = random_item();
            fill.opcode       = OP_TRANS;
            fill.entry_state  = word_state();
            fill.letter       = it.letter;
            fill.target_state = STATE_W'($urandom_range(0, live_states() - 1));
            send_item(fill);
        end
        send_item(it);
    endtask

    // hold off new items until every result is back
    task automatic drain();
        @(negedge clk);
        sym_valid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(tdfa_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_START_STATE:   cfg_start = data[STATE_W-1:0];
            CFG_ALPHABET_SIZE: cfg_alpha = data[ALPHA_W-1:0];
            CFG_STATE_COUNT:   cfg_count = data[COUNT_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one well-formed word, sometimes with loads in between letters
    task automatic send_word(int len);
        tdfa_in_t it;
        int slim;
        int llim;
        for (int i = 0; i < len; i++)
        begin
            slim = live_states();
            llim = live_letters();
            if ($urandom_range(0, 9) == 0)
            begin
                it = random_item();
                it.opcode = $urandom_range(0, 1) ? OP_TRANS : OP_MARK;
                if (slim > 0 && llim > 0)
                begin
                    it.entry_state  = STATE_W'($urandom_range(0, slim - 1));
                    it.letter       = LETTER_W'($urandom_range(0, llim - 1));
                    it.target_state = STATE_W'($urandom_range(0, slim - 1));
                end
                send_checked(it);
            end
            it = random_item();
            it.opcode   = OP_LETTER;
            it.letter   = (llim > 0) ? LETTER_W'($urandom_range(0, llim - 1))
                                     : LETTER_W'($urandom_range(0, 31));
            it.word_end = (i == len - 1);
            send_checked(it);
        end
    endtask

    // extremes, every opcode, out-of-range cases, loads inside a word
    task automatic test_directed();
        send_item(make_item(OP_MARK, 3, 0, 0, 1, 0));
        send_item(make_item(OP_MARK, 15, 31, 15, 1, 1));
        for (int s = 0; s < 4; s++)
            for (int l = 0; l < 2; l++)
                send_item(make_item(OP_TRANS, s, l, (2 * s + l + 1) % 4, 0, 0));
        send_item(make_item(OP_TRANS, 15, 0, 0, 0, 0));
        send_item(make_item(OP_TRANS, 0, 31, 0, 0, 0));
        send_item(make_item(OP_TRANS, 0, 0, 15, 1, 1));
        send_item(make_item(OP_NOP, 15, 31, 15, 1, 1));
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 0));
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 1));
        send_checked(make_item(OP_LETTER, 15, 31, 15, 1, 1));
        send_checked(make_item(OP_LETTER, 0, 1, 0, 0, 1));
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 0));
        send_item(make_item(OP_MARK, 3, 0, 0, 0, 0));
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 1));
        send_item(make_item(OP_MARK, 3, 0, 0, 1, 0));
    endtask

    // register changes around open words and out-of-range running states
    task automatic test_config_edges();
        // start state changed inside a word applies to the next word only
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 0));
        drain();
        write_reg(CFG_START_STATE, 6'd2);
        send_checked(make_item(OP_LETTER, 0, 1, 0, 0, 1));
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 1));
        // start state beyond the state count
        drain();
        write_reg(CFG_START_STATE, 6'd15);
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 1));
        drain();
        write_reg(CFG_START_STATE, 6'd0);
        // state count shrinks below the running state mid-word
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 0));
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 0));
        drain();
        write_reg(CFG_STATE_COUNT, 6'd2);
        send_checked(make_item(OP_LETTER, 0, 0, 0, 0, 1));
        send_item(make_item(OP_MARK, 3, 0, 0, 0, 0));
        drain();
        write_reg(CFG_STATE_COUNT, 6'd4);
    endtask

    // long receiver hold-off while items keep coming, then random receiver stalls at a 50 percent rate
    task automatic test_backpressure();
        gap_max   = 0;
        stall_pct = 0;
        hold_req  = hold_req + 1;
        repeat (6) send_word($urandom_range(3, 8));
        drain();
        stall_pct = 50;
        repeat (4) send_word($urandom_range(1, 8));
        drain();
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] start, logic [CFG_DATA_W-1:0] alpha,
                             logic [CFG_DATA_W-1:0] count, int gmax, int spct, int n);
        int stop;
        tdfa_in_t it;
        drain();
        write_reg(CFG_START_STATE, start);
        write_reg(CFG_ALPHABET_SIZE, alpha);
        write_reg(CFG_STATE_COUNT, count);
        gap_max   = gmax;
        stall_pct = spct;
        stop      = items_sent + n;
        // fresh accepting marks for the states in use
        for (int s = 0; s < live_states(); s++)
            send_item(make_item(OP_MARK, s, 0, 0, $urandom_range(0, 1), 0));
        // mostly whole words, the rest any item at all
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 99) < 70)
                send_word($urandom_range(1, 8));
            else
            begin
                it = random_item();
                send_checked(it);
            end
        end
    endtask

    task automatic test_random_phases();
        run_phase(6'd0, 6'd2, 6'd4, 4, 20, 100);
        run_phase(6'd0, 6'd32, 6'd16, 6, 30, 150);
        run_phase(6'd15, 6'd32, 6'd16, 0, 0, 100);
        run_phase(6'd0, 6'd1, 6'd1, 3, 50, 80);
        run_phase(6'd7, 6'd5, 6'd9, 5, 25, 120);
        run_phase(6'd63, 6'd63, 6'd63, 2, 40, 100);
        run_phase(6'd3, 6'd0, 6'd0, 3, 20, 40);
        run_phase(6'd9, 6'd4, 6'd8, 3, 20, 60);
        repeat (2)
            run_phase(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(1, 32)),
                      CFG_DATA_W'($urandom_range(1, 16)),
                      $urandom_range(0, 6), $urandom_range(0, 60), 150);
    endtask

    // receiver stall pattern with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_req;
        end
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else
            res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        tdfa_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: state %0d done %0b accepted %0b error %0b",
                             res_item.current_state, res_item.word_done,
                             res_item.word_accepted, res_item.range_error);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (res_item.current_state !== want.current_state
                    || res_item.word_done !== want.word_done
                    || res_item.word_accepted !== want.word_accepted
                    || res_item.range_error !== want.range_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: expected state %0d done %0b accepted %0b",
                                  " error %0b, got state %0d done %0b accepted %0b error %0b"},
                                 $realtime, want.current_state, want.word_done,
                                 want.word_accepted, want.range_error,
                                 res_item.current_state, res_item.word_done,
                                 res_item.word_accepted, res_item.range_error);
                end
            end
        end
    end

    // stop a hung run
    always @(posedge clk)
    begin
        if (!rst_n || (sym_valid && !sym_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("table_driven_dfa_engine_top test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_config_edges();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("table_driven_dfa_engine_top test passed");
        else
        begin
            if (expected_outcomes.size() != 0)
                $display("%0d results never arrived", expected_outcomes.size());
            $display("table_driven_dfa_engine_top test failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/tdfa_pkg.sv
rtl/tdfa_table.sv
rtl/table_driven_dfa_engine_top.sv
tb/tb_table_driven_dfa_engine_top.sv
